### hdl/assert_macros.svh
// Assertion macros for the block-cache checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hdl/lbc_pkg.sv
package lbc_pkg;

    // Request fields
    localparam int ADDR_W      = 20;
    localparam int CHUNK_BITS  = 4;                  // 16 chunks per block
    localparam int BNO_W       = ADDR_W - CHUNK_BITS;
    localparam int HW_W        = BNO_W + 1;          // high-water can reach 2^BNO_W - 1

    // Block geometry: 16 chunks of 32 bytes
    localparam int CHUNK_SHIFT = 5;
    localparam int OFF_W       = CHUNK_BITS + CHUNK_SHIFT;
    localparam int LEFT_W      = OFF_W + 1;
    localparam logic [LEFT_W-1:0] BLOCK_BYTES = LEFT_W'(1 << OFF_W);

    // Block numbers at or above 2^16 - 1 are rejected
    localparam logic [BNO_W-1:0] BLOCK_LIMIT = {BNO_W{1'b1}};

    // Result field widths
    localparam int SLOT_OUT_W  = 3;
    localparam int FLUSH_W     = 8;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic [OFF_W-1:0]      byte_offset;
        logic [LEFT_W-1:0]     bytes_left;
        logic                  fetch_block;
        logic [FLUSH_W-1:0]    flush_mask;
        logic                  too_large;
    } res_t;

endpackage

### hdl/lbc_ram.sv
module lbc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/lru_block_cache_controller.sv
// Channel   Handshake            Payload
// --------  -------------------  ---------------------------------------------------
// req       req_valid/req_stall  chunk_address[19:0], is_write
// rsp       rsp_valid/rsp_stall  hit, slot[2:0], byte_offset[8:0], bytes_left[9:0],
//                                fetch_block, flush_mask[7:0], too_large
//
// Sequence: one request at a time; the tag store is scanned by one shared comparator,
//   one slot per cycle. A too-large request goes straight to the result step; a request
//   for the block used last skips the scan; a hit ends the scan at its slot; a miss
//   scans all SLOTS slots. The tag RAM's registered read sets the scan pace.
// Reset: rst_n async, active low; slot i holds block i, all clean, rank i = slot i.
// Stalls: req_stall is high while a request is in work; a done result waits in res_reg.
module lru_block_cache_controller #(
    parameter int SLOTS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request channel
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  logic [lbc_pkg::ADDR_W-1:0]            chunk_address,
    input  logic                                  is_write,
    // result channel
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output logic                                  hit,
    output logic [lbc_pkg::SLOT_OUT_W-1:0]        slot,
    output logic [lbc_pkg::OFF_W-1:0]             byte_offset,
    output logic [lbc_pkg::LEFT_W-1:0]            bytes_left,
    output logic                                  fetch_block,
    output logic [lbc_pkg::FLUSH_W-1:0]           flush_mask,
    output logic                                  too_large
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [SLOT_W-1:0] MRU_RANK = SLOT_W'(SLOTS - 1);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;   // waiting for a request
    localparam logic [2:0] S_LAST = 3'd1;   // compare against last-used slot
    localparam logic [2:0] S_SCAN = 3'd2;   // walk tags, one slot per cycle
    localparam logic [2:0] S_UPD  = 3'd3;   // apply LRU / dirty / high-water update
    localparam logic [2:0] S_OUT  = 3'd4;   // load result register

    logic [2:0]                   state_reg, state_next;

    // latched request
    logic [lbc_pkg::BNO_W-1:0]      bno_reg;
    logic [lbc_pkg::CHUNK_BITS-1:0] chunk_reg;
    logic                           wr_reg;

    // scan bookkeeping
    logic [SLOT_W-1:0]            idx_reg;
    logic [SLOT_W-1:0]            sel_reg;      // slot of a scan hit
    logic [SLOT_W-1:0]            victim_reg;   // slot holding rank 0
    logic                         found_reg;
    logic                         last_hit_reg;

    // cache state
    logic [SLOT_W-1:0]            rank_reg [SLOTS];
    logic [SLOTS-1:0]             dirty_reg;
    logic [SLOTS-1:0]             tvalid_reg;   // tag RAM entry written since reset
    logic [lbc_pkg::HW_W-1:0]     hw_reg;
    logic [SLOT_W-1:0]            last_slot_reg;
    logic                         last_valid_reg;

    // tag RAM read side
    logic [SLOT_W-1:0]            rd_addr;
    logic [SLOT_W-1:0]            rd_slot_reg;
    logic                         rd_tv_reg;
    logic [lbc_pkg::BNO_W-1:0]    tag_rdata;
    logic [lbc_pkg::BNO_W-1:0]    tag_eff;
    logic                         tag_match;

    // result staging and output
    lbc_pkg::res_t                res_reg;
    lbc_pkg::res_t                out_reg;
    logic                         rsp_valid_reg;

    logic                         req_xfer;
    logic                         req_big;
    logic                         out_free;

    // update-step signals
    logic                         miss;
    logic [SLOT_W-1:0]            upd_slot;
    logic [SLOT_W-1:0]            rank_sel;
    logic [SLOTS-1:0]             rank_zero;
    logic [SLOTS-1:0]             flush_vec;
    logic [SLOTS-1:0]             dirty_upd;
    logic [lbc_pkg::HW_W-1:0]     bno_ext;
    logic                         below_hw;
    logic [lbc_pkg::OFF_W-1:0]    off;

    assign req_stall = (state_reg != S_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign req_big   = (chunk_address[lbc_pkg::ADDR_W-1:lbc_pkg::CHUNK_BITS]
                        == lbc_pkg::BLOCK_LIMIT);
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // Tag store: entries not yet written read back as their reset tag (slot i -> i).
    lbc_ram #(
        .WIDTH (lbc_pkg::BNO_W),
        .DEPTH (SLOTS)
    ) u_tag_ram (
        .clk   (clk),
        .we    ((state_reg == S_UPD) && miss),
        .waddr (victim_reg),
        .wdata (bno_reg),
        .raddr (rd_addr),
        .rdata (tag_rdata)
    );

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  rd_addr = last_slot_reg;
            S_LAST:  rd_addr = '0;
            S_SCAN:  rd_addr = idx_reg + SLOT_W'(1);
            default: rd_addr = '0;
        endcase
    end

    // the shared comparator
    assign tag_eff   = rd_tv_reg ? tag_rdata : lbc_pkg::BNO_W'(rd_slot_reg);
    assign tag_match = (tag_eff == bno_reg);

    // per-slot rank-zero flags, picked by the scan index
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            rank_zero[i] = (rank_reg[i] == '0);
        end
    end

    // update step
    assign miss     = !found_reg && !last_hit_reg;
    assign upd_slot = last_hit_reg ? last_slot_reg : (found_reg ? sel_reg : victim_reg);
    assign rank_sel = rank_reg[upd_slot];
    assign bno_ext  = {1'b0, bno_reg};
    assign below_hw = (bno_ext < hw_reg);
    assign flush_vec = (miss && dirty_reg[victim_reg]) ? dirty_reg : '0;
    assign off      = {chunk_reg, {lbc_pkg::CHUNK_SHIFT{1'b0}}};

    always_comb
    begin
        dirty_upd = dirty_reg & ~flush_vec;
        if (miss)
        begin
            dirty_upd[victim_reg] = 1'b0;
        end
        if (wr_reg)
        begin
            dirty_upd[upd_slot] = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = req_big ? S_OUT : S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = (last_valid_reg && tag_match) ? S_UPD : S_SCAN;
            end
            S_SCAN:
            begin
                if (tag_match || (idx_reg == LAST_IDX))
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and cache state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            dirty_reg      <= '0;
            tvalid_reg     <= '0;
            hw_reg         <= '0;
            last_slot_reg  <= '0;
            last_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            last_hit_reg   <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                rank_reg[i] <= SLOT_W'(i);
            end
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_LAST)
            begin
                last_hit_reg <= last_valid_reg && tag_match;
                found_reg    <= 1'b0;
            end

            if ((state_reg == S_SCAN) && tag_match)
            begin
                found_reg <= 1'b1;
            end

            if (state_reg == S_UPD)
            begin
                if (!last_hit_reg)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (SLOT_W'(i) == upd_slot)
                        begin
                            rank_reg[i] <= MRU_RANK;
                        end
                        else if (rank_reg[i] > rank_sel)
                        begin
                            rank_reg[i] <= rank_reg[i] - SLOT_W'(1);
                        end
                    end
                    if (!below_hw)
                    begin
                        hw_reg <= bno_ext + lbc_pkg::HW_W'(1);
                    end
                end
                if (miss)
                begin
                    tvalid_reg[victim_reg] <= 1'b1;
                end
                dirty_reg      <= dirty_upd;
                last_slot_reg  <= upd_slot;
                last_valid_reg <= 1'b1;
            end

            if ((state_reg == S_OUT) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_slot_reg <= rd_addr;
        rd_tv_reg   <= tvalid_reg[rd_addr];

        if (req_xfer)
        begin
            bno_reg   <= chunk_address[lbc_pkg::ADDR_W-1:lbc_pkg::CHUNK_BITS];
            chunk_reg <= chunk_address[lbc_pkg::CHUNK_BITS-1:0];
            wr_reg    <= is_write;
            // a too-large request reports all fields zero but the flag
            res_reg.hit         <= 1'b0;
            res_reg.slot        <= '0;
            res_reg.byte_offset <= '0;
            res_reg.bytes_left  <= '0;
            res_reg.fetch_block <= 1'b0;
            res_reg.flush_mask  <= '0;
            res_reg.too_large   <= req_big;
        end

        if (state_reg == S_LAST)
        begin
            idx_reg <= '0;
        end
        else if (state_reg == S_SCAN)
        begin
            idx_reg <= idx_reg + SLOT_W'(1);
            if (tag_match)
            begin
                sel_reg <= idx_reg;
            end
        end

        // victim found during the walk; ranks are fixed until the update step
        if ((state_reg == S_SCAN) && rank_zero[idx_reg])
        begin
            victim_reg <= idx_reg;
        end

        if (state_reg == S_UPD)
        begin
            res_reg.hit         <= !miss;
            res_reg.slot        <= lbc_pkg::SLOT_OUT_W'(upd_slot);
            res_reg.byte_offset <= off;
            res_reg.bytes_left  <= lbc_pkg::BLOCK_BYTES - {1'b0, off};
            res_reg.fetch_block <= miss && below_hw;
            res_reg.flush_mask  <= lbc_pkg::FLUSH_W'(flush_vec);
            res_reg.too_large   <= 1'b0;
        end

        if ((state_reg == S_OUT) && out_free)
        begin
            out_reg <= res_reg;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign hit         = out_reg.hit;
    assign slot        = out_reg.slot;
    assign byte_offset = out_reg.byte_offset;
    assign bytes_left  = out_reg.bytes_left;
    assign fetch_block = out_reg.fetch_block;
    assign flush_mask  = out_reg.flush_mask;
    assign too_large   = out_reg.too_large;

endmodule

### hdl/lbc_checker.sv
`include "assert_macros.svh"

module lbc_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  req_valid,
    input logic                                  req_stall,
    input logic [lbc_pkg::ADDR_W-1:0]            chunk_address,
    input logic                                  is_write,
    input logic                                  rsp_valid,
    input logic                                  rsp_stall,
    input logic                                  hit,
    input logic [lbc_pkg::SLOT_OUT_W-1:0]        slot,
    input logic [lbc_pkg::OFF_W-1:0]             byte_offset,
    input logic [lbc_pkg::LEFT_W-1:0]            bytes_left,
    input logic                                  fetch_block,
    input logic [lbc_pkg::FLUSH_W-1:0]           flush_mask,
    input logic                                  too_large
);

    // one request in work at a time
    `ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && !req_stall, req_stall)

    // a new result only appears while the request side is held off
    `ASSERT_IMPLY(a_rsp_from_busy, clk, rst_n, $rose(rsp_valid), $past(req_stall))

    // a hit never fetches or flushes
    `ASSERT_IMPLY(a_hit_quiet, clk, rst_n, rsp_valid && hit,
                  !fetch_block && (flush_mask == '0) && !too_large)

    // stalled result holds
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall,
                 rsp_valid && $stable(slot) && $stable(flush_mask) && $stable(bytes_left))

endmodule

bind lru_block_cache_controller lbc_checker u_lbc_checker (.*);
